// ===== sv/rmez_pkg.sv =====
// ----------------------------------------------------------------------------
// rmez_pkg
// Shared constants, types and tables for the ZYZ Euler angle block.
// ----------------------------------------------------------------------------
package rmez_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int XW = 48;
    localparam int ZW = 34;
    localparam int SQW = 25;
    localparam int SQ_STEPS = 25;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629714;

    typedef logic signed [XW-1:0] cx_t;
    typedef logic signed [ZW-1:0] cz_t;

    typedef struct packed {
        cx_t x;
        cx_t y;
        cz_t z;
    } vec_t;

    typedef struct packed {
        logic        valid;
        logic        degen;
        logic        neg_a;
        logic        m22_pos;
        vec_t        va;
        vec_t        vb;
        vec_t        vg;
    } lane_t;

    function automatic cz_t atan_tab(input int i);
        cz_t t;
        case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837830;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            10: t = 34'sd1048576;
            default: t = cz_t'(34'sd1048576 >>> (i - 10));
        endcase
        return t;
    endfunction

    function automatic vec_t cordic_step(input vec_t v, input int i);
        vec_t r;
        cx_t dx;
        cx_t dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y > 0)
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + atan_tab(i);
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - atan_tab(i);
        end
        return r;
    endfunction

    function automatic vec_t pre_rot(input cx_t y, input cx_t x);
        vec_t r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                r.x = y;
                r.y = -x;
                r.z = HALF_PI_Q30;
            end
            else
            begin
                r.x = -y;
                r.y = x;
                r.z = -HALF_PI_Q30;
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] round_z(input cz_t z);
        cz_t t;
        t = z + cz_t'(65536);
        return t[32:17];
    endfunction

endpackage

// ===== sv/rmez_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmez_sqrt_cell
// One restoring square root step per cell, carrying the rest of the beat.
// ----------------------------------------------------------------------------
module rmez_sqrt_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [4:0]                      step,
    input  logic                            in_valid,
    input  logic [49:0]                     in_rem,
    input  logic [rmez_pkg::SQW-1:0]        in_root,
    input  logic signed [15:0]              in_c,
    input  rmez_pkg::lane_t                 in_lane,
    output logic                            out_valid,
    output logic [49:0]                     out_rem,
    output logic [rmez_pkg::SQW-1:0]        out_root,
    output logic signed [15:0]              out_c,
    output rmez_pkg::lane_t                 out_lane
);

    logic                       valid_reg;
    logic [49:0]                rem_reg;
    logic [49:0]                rem_next;
    logic [rmez_pkg::SQW-1:0]   root_reg;
    logic [rmez_pkg::SQW-1:0]   root_next;
    logic signed [15:0]         c_reg;
    rmez_pkg::lane_t            lane_reg;
    logic [49:0]                trial;
    logic [5:0]                 sh;

    always_comb
    begin
        sh = 6'(2 * (5'd24 - step));
        trial = {23'd0, in_root, 2'b01} << sh;
        if (in_rem >= trial)
        begin
            rem_next = in_rem - trial;
            root_next = (in_root << 1) | 25'd1;
        end
        else
        begin
            rem_next = in_rem;
            root_next = in_root << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        c_reg <= in_c;
        lane_reg <= in_lane;
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_root = root_reg;
    assign out_c = c_reg;
    assign out_lane = lane_reg;

endmodule

// ===== sv/rmez_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rmez_cordic_cell
// One CORDIC vectoring micro-rotation for each of the three angle lanes.
// ----------------------------------------------------------------------------
module rmez_cordic_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      step,
    input  rmez_pkg::lane_t in_lane,
    output rmez_pkg::lane_t out_lane
);

    rmez_pkg::lane_t lane_reg;
    rmez_pkg::lane_t lane_next;

    always_comb
    begin
        lane_next = in_lane;
        lane_next.va = rmez_pkg::cordic_step(in_lane.va, int'(step));
        lane_next.vb = rmez_pkg::cordic_step(in_lane.vb, int'(step));
        lane_next.vg = rmez_pkg::cordic_step(in_lane.vg, int'(step));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else
            lane_reg <= lane_next;
    end

    assign out_lane = lane_reg;

endmodule

// ===== sv/rotation_matrix_to_euler_zyz.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyz
// ZYZ Euler angles from seven rotation matrix elements, one beat per cycle.
// ----------------------------------------------------------------------------
// channel  ports                                     handshake
// config   gimbal_threshold_we, gimbal_threshold      write on we
// input    m00 m01 m02 m12 m20 m21 m22               start & !busy
// result   alpha beta gamma degenerate               done strobe
//
// One beat enters every cycle; busy is always low.
// Registers in order: 25 root cells, the lane register, CORDIC_STAGES cells, the result.
// Each root cell does one square root step, each CORDIC cell one rotation step.
// Reset clears the valid chain and sets the threshold to 4.
// The receiver cannot stall; done is high for one cycle per beat.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyz (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gimbal_threshold_we,
    input  logic [29:0]        gimbal_threshold,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               done,
    output logic signed [15:0] alpha,
    output logic [14:0]        beta,
    output logic signed [15:0] gamma,
    output logic               degenerate
);

    localparam int NS = rmez_pkg::SQ_STEPS;
    localparam int NC = rmez_pkg::CORDIC_STAGES;

    logic [29:0]        thr_reg;
    logic [31:0]        s_sq;
    logic signed [15:0] cs;
    logic [28:0]        csq;
    rmez_pkg::lane_t    in_lane;

    logic                       sv_valid [0:NS];
    logic [49:0]                sv_rem   [0:NS];
    logic [rmez_pkg::SQW-1:0]   sv_root  [0:NS];
    logic signed [15:0]         sv_c     [0:NS];
    rmez_pkg::lane_t            sv_lane  [0:NS];
    rmez_pkg::lane_t            cl       [0:NC];

    logic               done_reg;
    logic signed [15:0] alpha_reg;
    logic [14:0]        beta_reg;
    logic signed [15:0] gamma_reg;
    logic               degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 30'd4;
        else if (gimbal_threshold_we)
            thr_reg <= gimbal_threshold;
    end

    assign busy = 1'b0;

    always_comb
    begin
        s_sq = 32'(m02 * m02) + 32'(m12 * m12);
        cs = (m22 > 16'sd16384) ? 16'sd16384 : (m22 < -16'sd16384) ? -16'sd16384 : m22;
        csq = 29'(32'(cs * cs));
        in_lane = '0;
        in_lane.valid = start;
        in_lane.degen = !(s_sq > {2'b00, thr_reg});
        in_lane.neg_a = in_lane.degen;
        in_lane.m22_pos = m22 > 16'sd0;
        if (in_lane.degen)
            in_lane.va = rmez_pkg::pre_rot(rmez_pkg::cx_t'(m00) <<< 24,
                                           rmez_pkg::cx_t'(m01) <<< 24);
        else
            in_lane.va = rmez_pkg::pre_rot(rmez_pkg::cx_t'(m21) <<< 24,
                                           rmez_pkg::cx_t'(m20) <<< 24);
        in_lane.vg = rmez_pkg::pre_rot(rmez_pkg::cx_t'(m12) <<< 24,
                                       rmez_pkg::cx_t'(m02) <<< 24);
    end

    assign sv_valid[0] = start;
    assign sv_rem[0] = 50'(29'd268435456 - csq) << 20;
    assign sv_root[0] = '0;
    assign sv_c[0] = cs;
    assign sv_lane[0] = in_lane;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_sq
            rmez_sqrt_cell u_sq (
                .clk       (clk),
                .rst_n     (rst_n),
                .step      (5'(g)),
                .in_valid  (sv_valid[g]),
                .in_rem    (sv_rem[g]),
                .in_root   (sv_root[g]),
                .in_c      (sv_c[g]),
                .in_lane   (sv_lane[g]),
                .out_valid (sv_valid[g+1]),
                .out_rem   (sv_rem[g+1]),
                .out_root  (sv_root[g+1]),
                .out_c     (sv_c[g+1]),
                .out_lane  (sv_lane[g+1])
            );
        end
    endgenerate

    rmez_pkg::lane_t lb_reg;
    rmez_pkg::lane_t lb_next;

    always_comb
    begin
        lb_next = sv_lane[NS];
        lb_next.valid = sv_valid[NS];
        lb_next.vb = rmez_pkg::pre_rot(rmez_pkg::cx_t'(sv_root[NS]),
                                       rmez_pkg::cx_t'(sv_c[NS]) <<< 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lb_reg <= '0;
        else
            lb_reg <= lb_next;
    end

    assign cl[0] = lb_reg;

    generate
        for (g = 0; g < NC; g++)
        begin : g_cd
            rmez_cordic_cell u_cd (
                .clk      (clk),
                .rst_n    (rst_n),
                .step     (5'(g)),
                .in_lane  (cl[g]),
                .out_lane (cl[g+1])
            );
        end
    endgenerate

    logic signed [15:0] ra;
    logic signed [15:0] rb;
    logic signed [15:0] rg;

    always_comb
    begin
        ra = (cl[NC].va.x == 0 && cl[NC].va.y == 0) ? 16'sd0
             : rmez_pkg::round_z(cl[NC].va.z);
        rb = rmez_pkg::round_z(cl[NC].vb.z);
        rg = rmez_pkg::round_z(cl[NC].vg.z);
    end

    logic za;
    logic zg;
    assign za = 1'b0;
    assign zg = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cl[NC].valid;
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= za ? 16'sd0 : (cl[NC].neg_a ? -ra : ra);
        degen_reg <= cl[NC].degen;
        if (cl[NC].degen)
        begin
            beta_reg <= cl[NC].m22_pos ? 15'd0 : 15'(rmez_pkg::PI_Q13);
            gamma_reg <= 16'sd0;
        end
        else
        begin
            beta_reg <= 15'(rb);
            gamma_reg <= zg ? 16'sd0 : -rg;
        end
    end

    assign done = done_reg;
    assign alpha = alpha_reg;
    assign beta = beta_reg;
    assign gamma = gamma_reg;
    assign degenerate = degen_reg;

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy high");
    a_beta_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> beta <= 15'd25740)
        else $error("beta out of range");
    a_degen_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> gamma == 16'sd0)
        else $error("gamma not zero in gimbal lock");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NS + NC + 2) done)
        else $error("result strobe missing");

endmodule
